>>> hdl/bfloat16_elementwise_alu_macros.svh
// assertion macros for the bfloat16 element-wise unit
`ifndef BFLOAT16_ELEMENTWISE_ALU_MACROS_SVH
`define BFLOAT16_ELEMENTWISE_ALU_MACROS_SVH

// property must hold whenever reset is low
`define BF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

>>> hdl/bfea_pkg.sv
package bfea_pkg;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_MUL = 2'd1;
   localparam logic [1:0] OP_MIN = 2'd2;
   localparam logic [1:0] OP_MAX = 2'd3;

   localparam logic [15:0] QUIET_BIT   = 16'h0040;
   localparam logic [15:0] DEFAULT_NAN = 16'hFFC0;

   localparam int unsigned PIPE_DEPTH = 4;

   // stage record used by stage 2
   typedef struct packed {
      logic        vld;
      logic        last;
      logic        spec;     // result already fixed
      logic [15:0] fixed;
      logic        is_mul;
      logic        sign;
      logic signed [10:0] exp;   // unbiased-style working exponent
      logic [49:0] mag;      // significand with guard bits
   } stage_type;

   function automatic logic is_nan(input logic [15:0] x);
      return (x[14:7] == 8'hFF) && (x[6:0] != 7'd0);
   endfunction

   // a < b as floats, false when either is nan
   function automatic logic f_less(input logic [15:0] a, input logic [15:0] b);
      logic az;
      logic bz;
      begin
         az = (a[14:0] == 15'd0);
         bz = (b[14:0] == 15'd0);
         if (is_nan(a) || is_nan(b)) return 1'b0;
         if (az && bz) return 1'b0;
         if (a[15] != b[15]) return a[15];
         if (a[15]) return a[14:0] > b[14:0];
         return a[14:0] < b[14:0];
      end
   endfunction

endpackage

>>> hdl/bfloat16_elementwise_alu.sv
// bfloat16 element-wise unit: add, multiply, minimum, maximum
// input: req_type, req_a_bits, req_b_bits, req_last_in taken when start is high
//    and busy is low; busy is never raised, so a word can enter every cycle
// output: rsp_result_bits and rsp_last_out are shown for one cycle under rsp_valid
// path: an accepted word is registered in s1_ff, s2_ff, s3_ff and s4_ff in turn,
//    and its result is shown from s4_ff
// throughput: one word per cycle through the four register stages
//    (unpack, align/multiply, normalise, round/pack)
// operands are widened to binary32, computed with round-to-nearest-even and
//    subnormals, then the top sixteen bits are returned with no rounding
// minimum/maximum pass the chosen pattern through; nan or equal gives b
// reset clears the stage valid bits only; no word in flight survives it
// the receiver cannot stall, so every result is shown exactly once
module bfloat16_elementwise_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_a_bits,
   input  logic [15:0] req_b_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_result_bits,
   output logic        rsp_last_out
);
   import bfea_pkg::*;

   `include "bfloat16_elementwise_alu_macros.svh"

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // ---------------- stage 1: unpack and classify
   typedef struct packed {
      logic        vld;
      logic        last;
      logic        spec;
      logic [15:0] fixed;
      logic        is_mul;
      logic        sa;
      logic        sb;
      logic [9:0]  ea;      // effective biased exponents (subnormal -> 1)
      logic [9:0]  eb;
      logic [7:0]  ma;      // significand with hidden bit
      logic [7:0]  mb;
   } s1_type;

   s1_type s1_in, s1_ff;

   always_comb begin
      logic an, bn, ai, bi, az, bz;
      an = is_nan(req_a_bits);
      bn = is_nan(req_b_bits);
      ai = (req_a_bits[14:0] == 15'h7F80);
      bi = (req_b_bits[14:0] == 15'h7F80);
      az = (req_a_bits[14:0] == 15'd0);
      bz = (req_b_bits[14:0] == 15'd0);
      s1_in        = '0;
      s1_in.vld    = accept;
      s1_in.last   = req_last_in;
      s1_in.is_mul = (req_type == OP_MUL);
      s1_in.sa     = req_a_bits[15];
      s1_in.sb     = req_b_bits[15];
      s1_in.ea     = {2'b00, (req_a_bits[14:7] == 8'd0) ? 8'd1 : req_a_bits[14:7]};
      s1_in.eb     = {2'b00, (req_b_bits[14:7] == 8'd0) ? 8'd1 : req_b_bits[14:7]};
      s1_in.ma     = {(req_a_bits[14:7] != 8'd0), req_a_bits[6:0]};
      s1_in.mb     = {(req_b_bits[14:7] != 8'd0), req_b_bits[6:0]};
      case (req_type)
         OP_MIN: begin
            s1_in.spec  = 1'b1;
            s1_in.fixed = f_less(req_a_bits, req_b_bits) ? req_a_bits : req_b_bits;
         end
         OP_MAX: begin
            s1_in.spec  = 1'b1;
            s1_in.fixed = f_less(req_b_bits, req_a_bits) ? req_a_bits : req_b_bits;
         end
         OP_ADD: begin
            s1_in.spec = 1'b1;
            if (an)                   s1_in.fixed = req_a_bits | QUIET_BIT;
            else if (bn)              s1_in.fixed = req_b_bits | QUIET_BIT;
            else if (ai && bi && (req_a_bits[15] != req_b_bits[15]))
                                      s1_in.fixed = DEFAULT_NAN;
            else if (ai)              s1_in.fixed = req_a_bits;
            else if (bi)              s1_in.fixed = req_b_bits;
            else                      s1_in.spec  = 1'b0;
         end
         default: begin
            s1_in.spec = 1'b1;
            if (an)                   s1_in.fixed = req_a_bits | QUIET_BIT;
            else if (bn)              s1_in.fixed = req_b_bits | QUIET_BIT;
            else if ((ai && bz) || (bi && az))
                                      s1_in.fixed = DEFAULT_NAN;
            else if (ai || bi)
               s1_in.fixed = {req_a_bits[15] ^ req_b_bits[15], 15'h7F80};
            else if (az || bz)
               s1_in.fixed = {req_a_bits[15] ^ req_b_bits[15], 15'h0000};
            else                      s1_in.spec  = 1'b0;
         end
      endcase
   end

   // ---------------- stage 2: multiply or align and add
   // value = mag * 2^exp; mag is exact unless an add shift exceeds 40 (sticky 1)
   stage_type s2_in, s2_ff;

   always_comb begin
      logic [9:0]  d;
      logic [7:0]  ml;
      logic [7:0]  ms;
      logic [9:0]  el;
      logic        sl;
      logic        ss;
      logic [49:0] big;
      logic [49:0] sml;
      logic [15:0] prod;
      s2_in        = '0;
      s2_in.vld    = s1_ff.vld;
      s2_in.last   = s1_ff.last;
      s2_in.spec   = s1_ff.spec;
      s2_in.fixed  = s1_ff.fixed;
      s2_in.is_mul = s1_ff.is_mul;
      big  = '0;
      sml  = '0;
      prod = s1_ff.ma * s1_ff.mb;
      if ({s1_ff.ea, s1_ff.ma} >= {s1_ff.eb, s1_ff.mb}) begin
         el = s1_ff.ea; ml = s1_ff.ma; sl = s1_ff.sa;
         ms = s1_ff.mb; ss = s1_ff.sb; d = s1_ff.ea - s1_ff.eb;
      end else begin
         el = s1_ff.eb; ml = s1_ff.mb; sl = s1_ff.sb;
         ms = s1_ff.ma; ss = s1_ff.sa; d = s1_ff.eb - s1_ff.ea;
      end
      if (s1_ff.is_mul) begin
         // product of two 2^-7 scaled significands: 2^(ea+eb-254-14)
         s2_in.sign = s1_ff.sa ^ s1_ff.sb;
         s2_in.mag  = {34'd0, prod};
         s2_in.exp  = 11'(s1_ff.ea) + 11'(s1_ff.eb) - 11'sd254 - 11'sd14;
      end else begin
         // sum held with 40 fraction bits below the larger operand, exact unless d > 40
         big = {2'b00, ml, 40'd0};
         sml = (d > 10'd40) ? 50'd1 : ({2'b00, ms, 40'd0} >> d);
         s2_in.sign = sl;
         s2_in.mag  = (sl == ss) ? big + sml : big - sml;
         s2_in.exp  = 11'(el) - 11'sd127 - 11'sd47;
         // zero sum: negative only when both operands are negative zeros
         if (s2_in.mag == 50'd0) s2_in.sign = sl & ss;
      end
   end

   // ---------------- stage 3: normalise to 24-bit significand with sticky
   typedef struct packed {
      logic        vld;
      logic        last;
      logic        spec;
      logic [15:0] fixed;
      logic        sign;
      logic        zero;
      logic signed [10:0] exp;   // exponent of leading bit
      logic [26:0] sig;          // 24 bits + guard + round + sticky
   } s3_type;

   s3_type s3_in, s3_ff;

   always_comb begin
      logic [5:0]  lz;
      logic [49:0] sh;
      logic [5:0]  i;
      s3_in       = '0;
      s3_in.vld   = s2_ff.vld;
      s3_in.last  = s2_ff.last;
      s3_in.spec  = s2_ff.spec;
      s3_in.fixed = s2_ff.fixed;
      s3_in.sign  = s2_ff.sign;
      s3_in.zero  = (s2_ff.mag == 50'd0);
      lz = 6'd0;
      for (i = 6'd0; i < 6'd50; i = i + 6'd1) begin
         if (s2_ff.mag[i[5:0]]) lz = 6'd49 - i;
      end
      sh = s2_ff.mag << lz;
      s3_in.sig = {sh[49:24], |sh[23:0]};
      s3_in.exp = s2_ff.exp + 11'sd49 - 11'(lz);
   end

   // ---------------- stage 4: round to nearest even and pack, keep top half
   typedef struct packed {
      logic        vld;
      logic        last;
      logic [15:0] res;
   } s4_type;

   s4_type s4_in, s4_ff;

   always_comb begin
      logic signed [10:0] be;
      logic [10:0] dn;
      logic [26:0] sg;
      logic        st;
      logic [24:0] rnd;
      logic [7:0]  eo;
      logic [31:0] w;
      s4_in      = '0;
      s4_in.vld  = s3_ff.vld;
      s4_in.last = s3_ff.last;
      be = s3_ff.exp + 11'sd127;
      sg = s3_ff.sig;
      dn = '0;
      st = 1'b0;
      eo = '0;
      // denormalise below minimum exponent
      if (be < 11'sd1) begin
         dn = 11'sd1 - be;
         if (dn > 11'd26) begin
            st = |sg;
            sg = {26'd0, st};
         end else begin
            st = |(sg & ((27'd1 << dn) - 27'd1));
            sg = (sg >> dn) | {26'd0, st};
         end
         be = 11'sd0;
      end
      rnd = {1'b0, sg[26:3]} +
            {24'd0, sg[2] & (sg[1] | sg[0] | sg[3])};
      if (rnd[24]) begin
         rnd = rnd >> 1;
         be  = be + 11'sd1;
      end else if (be == 11'sd0 && rnd[23]) begin
         be  = 11'sd1;
      end
      if (be >= 11'sd255) begin
         w = {s3_ff.sign, 8'hFF, 23'd0};
      end else begin
         eo = be[7:0];
         w  = {s3_ff.sign, eo, rnd[22:0]};
      end
      if (s3_ff.zero) w = {s3_ff.sign, 31'd0};
      s4_in.res = s3_ff.spec ? s3_ff.fixed : w[31:16];
   end

   // ---------------- stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         s2_ff.vld <= 1'b0;
         s3_ff.vld <= 1'b0;
         s4_ff.vld <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign rsp_valid       = s4_ff.vld;
   assign rsp_result_bits = s4_ff.res;
   assign rsp_last_out    = s4_ff.last;

   // ---------------- checks
   `BF_ASSERT(a_busy_low, !busy, "busy raised")
   `BF_ASSERT_IMP(a_latency, $past(accept, PIPE_DEPTH), rsp_valid, "word lost in pipeline")
   `BF_ASSERT_IMP(a_no_ghost, rsp_valid, $past(s1_ff.vld, 3), "result without word")

endmodule
